// File: design/adjacency_matrix_bfs_dfs_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the graph search block.
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_MATRIX_BFS_DFS_MACROS_SVH
`define ADJACENCY_MATRIX_BFS_DFS_MACROS_SVH

// Same-cycle implication, disabled during reset
`define AMBFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ambfs assertion failed");

// Next-cycle implication, disabled during reset
`define AMBFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ambfs assertion failed");

`endif

// File: design/ambfs_pkg.sv
// ----------------------------------------------------------------------------
// ambfs_pkg
// Sizes, codes and helper functions of the graph search block.
// ----------------------------------------------------------------------------
package ambfs_pkg;

    // Built vertex count and the reach of the 4-bit vertex fields
    localparam int MAX_VERTICES   = 16;
    localparam int FIELD_VERTICES = 16;
    localparam int USE_VERTICES   = (MAX_VERTICES < FIELD_VERTICES) ? MAX_VERTICES
                                                                    : FIELD_VERTICES;

    localparam int VTX_W   = 4;                        // vertex field width
    localparam int NV_W    = 5;                        // vertex count register width
    localparam int IDX_W   = $clog2(USE_VERTICES);     // internal vertex index
    localparam int PTR_W   = $clog2(USE_VERTICES + 1); // pending pointers, counts
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;

    typedef logic [USE_VERTICES-1:0] t_row;
    typedef logic [IDX_W-1:0]        t_idx;

    // Command codes
    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_TRAVERSE = 1'b1;

    // Status codes
    localparam logic ST_OK         = 1'b0;
    localparam logic ST_BAD_VERTEX = 1'b1;

    // Traversal order codes
    localparam logic ORDER_BFS = 1'b0;
    localparam logic ORDER_DFS = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_VERTICES    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVERSAL_ORDER = 1'b1;

    localparam logic [NV_W-1:0] NV_RESET = NV_W'(16);

    // Control of the pending vertex store
    typedef struct packed {
        logic init;   // restart with a single start vertex
        logic push;
        logic pop;
        logic lifo;   // stack order when set, queue order otherwise
    } t_pend_ctl;

    // Bits of vertices below the count in use
    function automatic t_row mask_below(input logic [NV_W-1:0] n);
        t_row m;
        for (int i = 0; i < USE_VERTICES; i++) begin
            m[i] = (NV_W'(i) < n);
        end
        return m;
    endfunction

    // Index of the lowest set bit
    function automatic t_idx lowest_set(input t_row v);
        t_idx idx;
        idx = '0;
        for (int i = USE_VERTICES - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: design/ambfs_if.sv
// ----------------------------------------------------------------------------
// ambfs channel interfaces
// Valid/ready channels for commands, results and configuration writes.
// ----------------------------------------------------------------------------
interface ambfs_in_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [ambfs_pkg::VTX_W-1:0]  vertex_a;
    logic [ambfs_pkg::VTX_W-1:0]  vertex_b;

    modport source (output valid, output cmd, output vertex_a, output vertex_b,
                    input ready);
    modport sink   (input valid, input cmd, input vertex_a, input vertex_b,
                    output ready);
endinterface

interface ambfs_out_if;
    logic                         valid;
    logic                         ready;
    logic [ambfs_pkg::VTX_W-1:0]  visited_vertex;
    logic                         status;
    logic                         last;

    modport source (output valid, output visited_vertex, output status, output last,
                    input ready);
    modport sink   (input valid, input visited_vertex, input status, input last,
                    output ready);
endinterface

interface ambfs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ambfs_pkg::CFG_IDX_W-1:0]  index;
    logic [ambfs_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/adjacency_matrix_bfs_dfs.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_bfs_dfs
// Directed graph store with breadth-first and depth-first reachability walks.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                              Transaction
//  i_in     in   cmd, vertex_a, vertex_b              one command
//  o_out    out  visited_vertex, status, last         one result
//  i_cfg    in   index, data                          one register write
//
//  Add edge and bad start: one result, ready again once that result is taken.
//  Traverse: per visited vertex a pop step, a pick step for each pushed
//  neighbour and a last that finds none, and an emit step; the pace is
//  set by the lowest-bit pick unit that pushes one neighbour per cycle.
//  Reset clears the matrix at once; no clearing pass. A stalled result holds
//  the walk in its emit step; i_cfg is always ready.
`include "adjacency_matrix_bfs_dfs_macros.svh"

module adjacency_matrix_bfs_dfs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ambfs_in_if.sink    i_in,
    ambfs_out_if.source o_out,
    ambfs_cfg_if.sink   i_cfg
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_POP  = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [ambfs_pkg::NV_W-1:0]      r_num_vertices;
    logic                            r_order;
    ambfs_pkg::t_row                 r_visited, n_visited;
    ambfs_pkg::t_row                 r_row, n_row;
    ambfs_pkg::t_idx                 r_cur, n_cur;
    logic [ambfs_pkg::PTR_W-1:0]     r_count, n_count;
    logic                            r_out_valid, n_out_valid;
    logic [ambfs_pkg::VTX_W-1:0]     r_out_vertex, n_out_vertex;
    logic                            r_out_status, n_out_status;
    logic                            r_out_last, n_out_last;

    logic [ambfs_pkg::NV_W-1:0]      w_n_use;
    logic                            w_in_acc;
    logic                            w_a_ok;
    logic                            w_b_ok;
    logic                            w_out_free;
    logic                            w_emit_last;
    ambfs_pkg::t_row                 w_cand;
    ambfs_pkg::t_idx                 w_pick;
    ambfs_pkg::t_row                 w_adj_row;
    logic                            w_adj_wr;
    ambfs_pkg::t_pend_ctl            w_pend_ctl;
    ambfs_pkg::t_idx                 w_pend_vtx;
    ambfs_pkg::t_idx                 w_pend_top;
    logic                            w_pend_empty;

    // Vertex count in use, limited to the built size
    assign w_n_use = (r_num_vertices > ambfs_pkg::NV_W'(ambfs_pkg::USE_VERTICES))
                   ? ambfs_pkg::NV_W'(ambfs_pkg::USE_VERTICES) : r_num_vertices;

    assign w_a_ok = (ambfs_pkg::NV_W'(i_in.vertex_a) < w_n_use);
    assign w_b_ok = (ambfs_pkg::NV_W'(i_in.vertex_b) < w_n_use);

    assign i_in.ready = (r_state == S_IDLE) && !r_out_valid;
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // Shared pick unit: lowest unvisited neighbour in range
    assign w_cand = r_row & ~r_visited & ambfs_pkg::mask_below(w_n_use);
    assign w_pick = ambfs_pkg::lowest_set(w_cand);

    assign w_emit_last = w_pend_empty
                      || (r_count == ambfs_pkg::PTR_W'(ambfs_pkg::USE_VERTICES));

    assign w_adj_wr = w_in_acc && (i_in.cmd == ambfs_pkg::CMD_ADD_EDGE) && w_a_ok && w_b_ok;

    // Pending store control
    always_comb begin
        w_pend_ctl.init = w_in_acc && (i_in.cmd == ambfs_pkg::CMD_TRAVERSE) && w_a_ok;
        w_pend_ctl.push = (r_state == S_SCAN) && (w_cand != '0);
        w_pend_ctl.pop  = (r_state == S_POP);
        w_pend_ctl.lifo = (r_order == ambfs_pkg::ORDER_DFS);
        w_pend_vtx      = w_pend_ctl.init ? i_in.vertex_a[ambfs_pkg::IDX_W-1:0] : w_pick;
    end

    ambfs_adj_store u_adj (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_adj_wr),
        .i_wr_row  (i_in.vertex_a[ambfs_pkg::IDX_W-1:0]),
        .i_wr_col  (i_in.vertex_b[ambfs_pkg::IDX_W-1:0]),
        .i_rd_row  (w_pend_top),
        .o_rd_data (w_adj_row)
    );

    ambfs_pending u_pend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_pend_ctl),
        .i_vertex (w_pend_vtx),
        .o_top    (w_pend_top),
        .o_empty  (w_pend_empty)
    );

    // Configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vertices <= ambfs_pkg::NV_RESET;
            r_order        <= ambfs_pkg::ORDER_BFS;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                ambfs_pkg::CFG_NUM_VERTICES: begin
                    r_num_vertices <= i_cfg.data[ambfs_pkg::NV_W-1:0];
                end
                ambfs_pkg::CFG_TRAVERSAL_ORDER: begin
                    r_order <= i_cfg.data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_visited    = r_visited;
        n_row        = r_row;
        n_cur        = r_cur;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_vertex = r_out_vertex;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.cmd == ambfs_pkg::CMD_ADD_EDGE) begin
                        n_out_valid  = 1'b1;
                        n_out_vertex = '0;
                        n_out_status = (w_a_ok && w_b_ok) ? ambfs_pkg::ST_OK
                                                          : ambfs_pkg::ST_BAD_VERTEX;
                        n_out_last   = 1'b1;
                    end else if (!w_a_ok) begin
                        n_out_valid  = 1'b1;
                        n_out_vertex = '0;
                        n_out_status = ambfs_pkg::ST_BAD_VERTEX;
                        n_out_last   = 1'b1;
                    end else begin
                        n_visited = '0;
                        n_visited[i_in.vertex_a[ambfs_pkg::IDX_W-1:0]] = 1'b1;
                        n_count   = '0;
                        n_state   = S_POP;
                    end
                end
            end
            S_POP: begin
                n_cur   = w_pend_top;
                n_row   = w_adj_row;
                n_count = r_count + 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_cand != '0) begin
                    n_visited[w_pick] = 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_vertex = ambfs_pkg::VTX_W'(r_cur);
                    n_out_status = ambfs_pkg::ST_OK;
                    n_out_last   = w_emit_last;
                    n_state      = w_emit_last ? S_IDLE : S_POP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_visited    <= n_visited;
        r_row        <= n_row;
        r_cur        <= n_cur;
        r_out_vertex <= n_out_vertex;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.visited_vertex = r_out_vertex;
    assign o_out.status         = r_out_status;
    assign o_out.last           = r_out_last;

    // A final walk result returns the sequencer to idle
    `AMBFS_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, (r_state == S_EMIT) && w_out_free && w_emit_last, r_state == S_IDLE)
    // A pushed neighbour leaves the pending store non-empty
    `AMBFS_ASSERT_NEXT(a_push_nonempty, i_clk, i_rst_n, (r_state == S_SCAN) && (w_cand != '0), !w_pend_empty)
    // No walk visits more vertices than are built
    `AMBFS_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, r_state != S_IDLE, r_count <= ambfs_pkg::PTR_W'(ambfs_pkg::USE_VERTICES))

endmodule

// File: design/ambfs_adj_store.sv
// ----------------------------------------------------------------------------
// ambfs_adj_store
// Adjacency bit matrix: one row per source vertex, cleared at reset.
// ----------------------------------------------------------------------------
module ambfs_adj_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  ambfs_pkg::t_idx    i_wr_row,
    input  ambfs_pkg::t_idx    i_wr_col,
    input  ambfs_pkg::t_idx    i_rd_row,
    output ambfs_pkg::t_row    o_rd_data
);

    ambfs_pkg::t_row r_rows [ambfs_pkg::USE_VERTICES];

    // Set one edge bit, clear all rows at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '{default: '0};
        end else if (i_wr_en) begin
            r_rows[i_wr_row][i_wr_col] <= 1'b1;
        end
    end

    assign o_rd_data = r_rows[i_rd_row];

endmodule

// File: design/ambfs_pending.sv
// ----------------------------------------------------------------------------
// ambfs_pending
// Pending vertex store, used as a queue or as a stack.
// ----------------------------------------------------------------------------
module ambfs_pending (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ambfs_pkg::t_pend_ctl i_ctl,
    input  ambfs_pkg::t_idx      i_vertex,
    output ambfs_pkg::t_idx      o_top,
    output logic                 o_empty
);

    ambfs_pkg::t_idx                r_entry [ambfs_pkg::USE_VERTICES];
    logic [ambfs_pkg::PTR_W-1:0]    r_head;
    logic [ambfs_pkg::PTR_W-1:0]    r_tail;
    logic [ambfs_pkg::PTR_W-1:0]    w_tail_m1;

    assign w_tail_m1 = r_tail - 1'b1;

    // Pop from the tail for a stack, from the head for a queue
    assign o_top   = i_ctl.lifo ? r_entry[w_tail_m1[ambfs_pkg::IDX_W-1:0]]
                                : r_entry[r_head[ambfs_pkg::IDX_W-1:0]];
    assign o_empty = (r_head == r_tail);

    // Pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else if (i_ctl.init) begin
            r_head <= '0;
            r_tail <= ambfs_pkg::PTR_W'(1);
        end else if (i_ctl.push) begin
            r_tail <= r_tail + 1'b1;
        end else if (i_ctl.pop) begin
            if (i_ctl.lifo) begin
                r_tail <= w_tail_m1;
            end else begin
                r_head <= r_head + 1'b1;
            end
        end
    end

    // Entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_entry[0] <= i_vertex;
        end else if (i_ctl.push) begin
            r_entry[r_tail[ambfs_pkg::IDX_W-1:0]] <= i_vertex;
        end
    end

endmodule

// File: tb/adjacency_matrix_bfs_dfs_checker.sv
// ----------------------------------------------------------------------------
// Graph search result checker
// Watches the command, result and register channels of the graph search
// block. It keeps its own adjacency matrix and register copy, builds the
// visit list of every accepted command, and compares each result field by
// field with the oldest visit still owed.
// ----------------------------------------------------------------------------
module adjacency_matrix_bfs_dfs_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ambfs_in_if   i_cmd,
    ambfs_out_if  i_res,
    ambfs_cfg_if  i_cfg,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ambfs_pkg::VTX_W-1:0] vertex;
        logic                        status;
        logic                        last;
    } t_visit;

    ambfs_pkg::t_row             graph [ambfs_pkg::USE_VERTICES];
    logic [ambfs_pkg::NV_W-1:0]  nv_cfg;
    logic                        order_cfg;
    t_visit                      visit_q [$];
    int                          fail_count = 0;
    int                          pending_n  = 0;
    int                          result_n   = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_n;

    // Apply one command to the local graph and queue the visits it owes
    task automatic walk_graph(input logic cmd, input logic [ambfs_pkg::VTX_W-1:0] va,
                              input logic [ambfs_pkg::VTX_W-1:0] vb);
        int                          n;
        int                          head;
        int                          tail;
        int                          count;
        int                          s;
        ambfs_pkg::t_row             marks;
        logic [ambfs_pkg::VTX_W-1:0] pend [ambfs_pkg::USE_VERTICES];
        t_visit                      r;
        n = (int'(nv_cfg) > ambfs_pkg::USE_VERTICES) ? ambfs_pkg::USE_VERTICES
                                                     : int'(nv_cfg);
        if (cmd == ambfs_pkg::CMD_ADD_EDGE) begin
            if (int'(va) < n && int'(vb) < n) begin
                graph[va][vb] = 1'b1;
                visit_q.push_back('{'0, ambfs_pkg::ST_OK, 1'b1});
            end else begin
                visit_q.push_back('{'0, ambfs_pkg::ST_BAD_VERTEX, 1'b1});
            end
        end else if (int'(va) >= n) begin
            visit_q.push_back('{'0, ambfs_pkg::ST_BAD_VERTEX, 1'b1});
        end else begin
            // Mark on push; neighbours go in ascending order
            marks     = '0;
            marks[va] = 1'b1;
            pend[0]   = va;
            head      = 0;
            tail      = 1;
            count     = 0;
            while (head < tail && count < ambfs_pkg::USE_VERTICES) begin
                if (order_cfg == ambfs_pkg::ORDER_DFS) begin
                    tail = tail - 1;
                    s    = int'(pend[tail]);
                end else begin
                    s    = int'(pend[head]);
                    head = head + 1;
                end
                visit_q.push_back('{ambfs_pkg::VTX_W'(s), ambfs_pkg::ST_OK, 1'b0});
                count = count + 1;
                for (int i = 0; i < n; i++) begin
                    if (graph[s][i] && !marks[i]) begin
                        marks[i]   = 1'b1;
                        pend[tail] = ambfs_pkg::VTX_W'(i);
                        tail       = tail + 1;
                    end
                end
            end
            // Flag the final visit of the walk
            r      = visit_q.pop_back();
            r.last = 1'b1;
            visit_q.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_visit want;
        if (!i_rst_n) begin
            for (int i = 0; i < ambfs_pkg::USE_VERTICES; i++) begin
                graph[i] = '0;
            end
            nv_cfg    = ambfs_pkg::NV_RESET;
            order_cfg = ambfs_pkg::ORDER_BFS;
            visit_q.delete();
        end else begin
            // Track register writes
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    ambfs_pkg::CFG_NUM_VERTICES:    nv_cfg    = i_cfg.data;
                    ambfs_pkg::CFG_TRAVERSAL_ORDER: order_cfg = i_cfg.data[0];
                    default: ;
                endcase
            end

            // Compare each result transaction with the oldest owed visit
            if (i_res.valid && i_res.ready) begin
                if (visit_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("checker: result %0d arrived with none owed:", result_n,
                                 " vertex=%0d status=%0d last=%0d",
                                 i_res.visited_vertex, i_res.status, i_res.last);
                    end
                end else begin
                    want = visit_q.pop_front();
                    if (i_res.visited_vertex !== want.vertex || i_res.status !== want.status ||
                        i_res.last !== want.last) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("checker: result %0d wrong:", result_n,
                                     " want vertex=%0d status=%0d last=%0d,",
                                     want.vertex, want.status, want.last,
                                     " got vertex=%0d status=%0d last=%0d",
                                     i_res.visited_vertex, i_res.status, i_res.last);
                        end
                    end
                end
                result_n++;
            end

            // Predict the visits of each command transaction
            if (i_cmd.valid && i_cmd.ready) begin
                walk_graph(i_cmd.cmd, i_cmd.vertex_a, i_cmd.vertex_b);
            end
        end
        pending_n <= visit_q.size();
    end

endmodule

// File: tb/adjacency_matrix_bfs_dfs_test.sv
// ----------------------------------------------------------------------------
// Graph search block test
// Drives edge inserts and breadth-first and depth-first walks into the
// graph search block under changing vertex counts, with random gaps on the
// command side and random back-pressure on the result side. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module adjacency_matrix_bfs_dfs_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_n;
    int   pending_n;
    int   cycle_n = 0;
    logic no_idle = 1'b0;
    int   nv_use  = ambfs_pkg::USE_VERTICES;

    ambfs_in_if  cmd_ch ();
    ambfs_out_if res_ch ();
    ambfs_cfg_if cfg_ch ();

    adjacency_matrix_bfs_dfs i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    adjacency_matrix_bfs_dfs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_n),
        .o_pending    (pending_n)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stall the result side at random, except in a quiet phase
    always @(negedge i_clk) begin
        res_ch.ready <= no_idle || ($urandom_range(99) >= 19);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_n++;
        if (cycle_n > CYCLE_LIMIT) begin
            $display("adjacency_matrix_bfs_dfs: mismatch");
            $finish;
        end
    end

    // Present one command and hold it until the block takes it
    task automatic send_cmd(input logic cmd, input logic [ambfs_pkg::VTX_W-1:0] va,
                            input logic [ambfs_pkg::VTX_W-1:0] vb);
        while (!no_idle && $urandom_range(99) < 19) begin
            @(negedge i_clk);
        end
        cmd_ch.valid    = 1'b1;
        cmd_ch.cmd      = cmd;
        cmd_ch.vertex_a = va;
        cmd_ch.vertex_b = vb;
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
        cmd_ch.valid = 1'b0;
    endtask

    // Write one register once every owed result is back
    task automatic write_cfg(input logic [ambfs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ambfs_pkg::CFG_DAT_W-1:0] data);
        wait (pending_n == 0);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
        if (idx == ambfs_pkg::CFG_NUM_VERTICES) begin
            nv_use = (int'(data) > ambfs_pkg::USE_VERTICES) ? ambfs_pkg::USE_VERTICES
                                                            : int'(data);
        end
    endtask

    // Pick a vertex, mostly inside the count in use
    function automatic logic [ambfs_pkg::VTX_W-1:0] pick_vertex();
        if (nv_use > 0 && $urandom_range(99) < 85) begin
            return ambfs_pkg::VTX_W'($urandom_range(nv_use - 1));
        end
        return ambfs_pkg::VTX_W'($urandom_range(15));
    endfunction

    initial begin : stimulus
        logic [ambfs_pkg::NV_W-1:0] nv;
        int                         pick;
        i_rst_n         = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.cmd      = ambfs_pkg::CMD_ADD_EDGE;
        cmd_ch.vertex_a = '0;
        cmd_ch.vertex_b = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = ambfs_pkg::CFG_NUM_VERTICES;
        cfg_ch.data     = '0;
        res_ch.ready    = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Small graph with field extremes and a self loop, breadth-first walks
        send_cmd(ambfs_pkg::CMD_ADD_EDGE, 4'd0, 4'd15);
        send_cmd(ambfs_pkg::CMD_ADD_EDGE, 4'd15, 4'd0);
        send_cmd(ambfs_pkg::CMD_ADD_EDGE, 4'd0, 4'd1);
        send_cmd(ambfs_pkg::CMD_ADD_EDGE, 4'd1, 4'd2);
        send_cmd(ambfs_pkg::CMD_ADD_EDGE, 4'd0, 4'd2);
        send_cmd(ambfs_pkg::CMD_ADD_EDGE, 4'd2, 4'd15);
        send_cmd(ambfs_pkg::CMD_ADD_EDGE, 4'd15, 4'd15);
        send_cmd(ambfs_pkg::CMD_TRAVERSE, 4'd0, 4'd15);
        send_cmd(ambfs_pkg::CMD_TRAVERSE, 4'd15, 4'd0);
        send_cmd(ambfs_pkg::CMD_TRAVERSE, 4'd3, 4'd0);

        // Depth-first walk over the same graph
        write_cfg(ambfs_pkg::CFG_TRAVERSAL_ORDER,
                  ambfs_pkg::CFG_DAT_W'(ambfs_pkg::ORDER_DFS));
        send_cmd(ambfs_pkg::CMD_TRAVERSE, 4'd0, 4'd0);

        // No vertex in use: everything is out of range
        write_cfg(ambfs_pkg::CFG_NUM_VERTICES, 5'd0);
        send_cmd(ambfs_pkg::CMD_ADD_EDGE, 4'd0, 4'd0);
        send_cmd(ambfs_pkg::CMD_TRAVERSE, 4'd0, 4'd0);

        // Shrunken count hides vertex 15 and its edges
        write_cfg(ambfs_pkg::CFG_NUM_VERTICES, 5'd3);
        send_cmd(ambfs_pkg::CMD_ADD_EDGE, 4'd2, 4'd3);
        send_cmd(ambfs_pkg::CMD_ADD_EDGE, 4'd3, 4'd0);
        send_cmd(ambfs_pkg::CMD_TRAVERSE, 4'd0, 4'd0);
        send_cmd(ambfs_pkg::CMD_TRAVERSE, 4'd5, 4'd10);

        // Grown back, the hidden edges count again
        write_cfg(ambfs_pkg::CFG_NUM_VERTICES, 5'd16);
        send_cmd(ambfs_pkg::CMD_TRAVERSE, 4'd0, 4'd0);

        // Count above the built size is limited
        write_cfg(ambfs_pkg::CFG_NUM_VERTICES, 5'd31);
        write_cfg(ambfs_pkg::CFG_TRAVERSAL_ORDER,
                  ambfs_pkg::CFG_DAT_W'(ambfs_pkg::ORDER_BFS));
        send_cmd(ambfs_pkg::CMD_TRAVERSE, 4'd15, 4'd15);

        // Single vertex with a self loop
        write_cfg(ambfs_pkg::CFG_NUM_VERTICES, 5'd1);
        send_cmd(ambfs_pkg::CMD_ADD_EDGE, 4'd0, 4'd0);
        send_cmd(ambfs_pkg::CMD_TRAVERSE, 4'd0, 4'd0);

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
                nv = 5'd0;
            end else if (pick == 1) begin
                nv = ambfs_pkg::NV_W'($urandom_range(31, 17));
            end else if (pick <= 4) begin
                nv = 5'd16;
            end else begin
                nv = ambfs_pkg::NV_W'($urandom_range(15, 1));
            end
            write_cfg(ambfs_pkg::CFG_NUM_VERTICES, nv);
            write_cfg(ambfs_pkg::CFG_TRAVERSAL_ORDER,
                      ambfs_pkg::CFG_DAT_W'($urandom_range(31)));
            no_idle = (p == 4) || (p == 5);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < 35) begin
                    send_cmd(ambfs_pkg::CMD_TRAVERSE, pick_vertex(),
                             ambfs_pkg::VTX_W'($urandom_range(15)));
                end else begin
                    send_cmd(ambfs_pkg::CMD_ADD_EDGE, pick_vertex(), pick_vertex());
                end
            end
        end
        no_idle = 1'b0;

        // Drain, then watch for stray results
        wait (pending_n == 0);
        repeat (200) @(posedge i_clk);
        if (fail_n == 0) begin
            $display("adjacency_matrix_bfs_dfs: match");
        end else begin
            $display("adjacency_matrix_bfs_dfs: mismatch");
        end
        $finish;
    end

endmodule
